// ===== sv/jls_pkg.sv =====
// jls_pkg: types and constants of the jacobi laplace grid solver core
// no dependencies; imported by jacobi_laplace_grid_solver_core and tb_top
package jls_pkg;

    localparam int MAX_SIDE      = 64;
    localparam int VALUE_BITS    = 24;
    localparam int FRACTION_BITS = 16;
    localparam int COORD_BITS    = $clog2(MAX_SIDE);
    localparam int ADDR_BITS     = 2 * COORD_BITS;
    localparam int SIDE_BITS     = COORD_BITS + 1;
    localparam int COUNT_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;

    // command codes
    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_SOLVE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_command;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_SIZE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_VALUE  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP_VALUE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_VALUE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWEEP_LIMIT = 3'd5;

    typedef struct packed {
        logic [1:0]            command;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] column;
    } t_cmd_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] cell_value;
        logic [COUNT_BITS-1:0] sweeps_done;
        logic                  converged;
    } t_result_item;

endpackage

// ===== sv/jacobi_laplace_grid_solver_core.sv =====
// jacobi_laplace_grid_solver_core: five-point jacobi heat solver on two grid banks
// depends on jls_pkg
//
// A command is taken when start is high and busy low; each command gives one
// result item, shown for one cycle with o_done high, and the receiver cannot
// stall it. Both grid banks are synchronous memories with one read and one
// write port, and every cell update reads its five stencil cells one at a time
// through the source bank's read port. Config writes are always ready and must
// only be issued while busy is low.
module jacobi_laplace_grid_solver_core
    import jls_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  t_cmd_item               i_cmd,
    output logic                    o_done,
    output t_result_item            o_result,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [VALUE_BITS-1:0]   i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_SWEEP = 6'b000100,
        S_CHECK = 6'b001000,
        S_READ  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    // configuration registers
    logic [SIDE_BITS-1:0]  r_grid_size;
    logic [VALUE_BITS-1:0] r_edge, r_top, r_start_val, r_tol;
    logic [COUNT_BITS-1:0] r_limit;

    // control and datapath registers
    t_state                r_state, n_state;
    logic [COORD_BITS-1:0] r_row, n_row, r_col, n_col;
    logic [2:0]            r_phase, n_phase;
    logic [VALUE_BITS+1:0] r_sum, n_sum;
    logic [VALUE_BITS-1:0] r_maxd, n_maxd;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_bank, n_bank;
    logic                  r_conv, n_conv;
    logic                  r_done, n_done;
    logic [VALUE_BITS-1:0] r_cell, n_cell;

    // grid banks
    logic [VALUE_BITS-1:0] mem0 [MAX_SIDE*MAX_SIDE];
    logic [VALUE_BITS-1:0] mem1 [MAX_SIDE*MAX_SIDE];
    logic [VALUE_BITS-1:0] r_rd0, r_rd1;
    logic [ADDR_BITS-1:0]  rd_addr, wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  wr0, wr1;

    logic [SIDE_BITS-1:0]  side, last, inner_last;
    logic [VALUE_BITS-1:0] src, nv, diff, init_val;

    // side in use, clamped to 3..MAX_SIDE
    always_comb begin
        priority if (r_grid_size < SIDE_BITS'(3)) side = SIDE_BITS'(3);
        else if (r_grid_size > SIDE_BITS'(MAX_SIDE)) side = SIDE_BITS'(MAX_SIDE);
        else side = r_grid_size;
    end
    assign last       = side - SIDE_BITS'(1);
    assign inner_last = side - SIDE_BITS'(2);

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign src         = r_bank ? r_rd1 : r_rd0;
    assign nv          = r_sum[VALUE_BITS+1:2];
    assign diff        = (nv > src) ? nv - src : src - nv;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= SIDE_BITS'(MAX_SIDE);
            r_edge      <= VALUE_BITS'(6553600);
            r_top       <= '0;
            r_start_val <= VALUE_BITS'(4915200);
            r_tol       <= VALUE_BITS'(7);
            r_limit     <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GRID_SIZE:   r_grid_size <= i_cfg_data[SIDE_BITS-1:0];
                REG_EDGE_VALUE:  r_edge      <= i_cfg_data;
                REG_TOP_VALUE:   r_top       <= i_cfg_data;
                REG_START_VALUE: r_start_val <= i_cfg_data;
                REG_TOLERANCE:   r_tol       <= i_cfg_data;
                REG_SWEEP_LIMIT: r_limit     <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // init value for the current cell
    always_comb begin
        priority if (r_col == '0 || {1'b0, r_col} == last || {1'b0, r_row} == last)
            init_val = r_edge;
        else if (r_row == '0) init_val = r_top;
        else init_val = r_start_val;
    end

    // stencil read address: up, down, left, right, center
    always_comb begin
        rd_addr = {r_row, r_col};
        if (r_state == S_IDLE) begin
            rd_addr = {i_cmd.row, i_cmd.column};
        end else begin
            unique case (r_phase)
                3'd0:    rd_addr = {r_row - COORD_BITS'(1), r_col};
                3'd1:    rd_addr = {r_row + COORD_BITS'(1), r_col};
                3'd2:    rd_addr = {r_row, r_col - COORD_BITS'(1)};
                3'd3:    rd_addr = {r_row, r_col + COORD_BITS'(1)};
                default: rd_addr = {r_row, r_col};
            endcase
        end
    end

    // bank write control
    always_comb begin
        wr_addr = {r_row, r_col};
        wr_data = (r_state == S_INIT) ? init_val : nv;
        wr0 = (r_state == S_INIT) || (r_state == S_SWEEP && r_phase == 3'd5 && r_bank);
        wr1 = (r_state == S_INIT) || (r_state == S_SWEEP && r_phase == 3'd5 && !r_bank);
    end

    always_ff @(posedge i_clk) begin
        if (wr0) mem0[wr_addr] <= wr_data;
        r_rd0 <= mem0[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr1) mem1[wr_addr] <= wr_data;
        r_rd1 <= mem1[rd_addr];
    end

    // command sequencer
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_phase = r_phase;
        n_sum   = r_sum;
        n_maxd  = r_maxd;
        n_count = r_count;
        n_bank  = r_bank;
        n_conv  = r_conv;
        n_done  = 1'b0;
        n_cell  = r_cell;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cell = '0;
                    n_row  = i_cmd.row;
                    n_col  = i_cmd.column;
                    unique case (t_command'(i_cmd.command))
                        CMD_INIT: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_state = S_INIT;
                        end
                        CMD_SOLVE: begin
                            n_row   = COORD_BITS'(1);
                            n_col   = COORD_BITS'(1);
                            n_phase = '0;
                            n_maxd  = '0;
                            n_count = '0;
                            n_state = S_SWEEP;
                        end
                        CMD_READ: n_state = S_READ;
                        CMD_NONE: n_state = S_FIN;
                    endcase
                end
            end
            S_INIT: begin
                if ({1'b0, r_col} == last) begin
                    n_col = '0;
                    if ({1'b0, r_row} == last) n_state = S_FIN;
                    else n_row = r_row + COORD_BITS'(1);
                end else begin
                    n_col = r_col + COORD_BITS'(1);
                end
            end
            S_SWEEP: begin
                n_phase = r_phase + 3'd1;
                unique case (r_phase)
                    3'd1:    n_sum = {2'b00, src};
                    3'd2, 3'd3, 3'd4: n_sum = r_sum + {2'b00, src};
                    3'd5: begin
                        n_phase = '0;
                        if (diff > r_maxd) n_maxd = diff;
                        if ({1'b0, r_col} == inner_last) begin
                            n_col = COORD_BITS'(1);
                            if ({1'b0, r_row} == inner_last) n_state = S_CHECK;
                            else n_row = r_row + COORD_BITS'(1);
                        end else begin
                            n_col = r_col + COORD_BITS'(1);
                        end
                    end
                    default: ;
                endcase
            end
            S_CHECK: begin
                n_bank  = !r_bank;
                n_count = r_count + COUNT_BITS'(1);
                n_row   = COORD_BITS'(1);
                n_col   = COORD_BITS'(1);
                n_maxd  = '0;
                if (r_maxd < r_tol) begin
                    n_conv  = 1'b1;
                    n_state = S_FIN;
                end else if (n_count >= r_limit) begin
                    n_conv  = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_READ: begin
                if ({1'b0, r_row} < side && {1'b0, r_col} < side) n_cell = src;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_count <= '0;
            r_bank  <= 1'b0;
            r_conv  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_bank  <= n_bank;
            r_conv  <= n_conv;
            r_done  <= n_done;
        end
        r_row  <= n_row;
        r_col  <= n_col;
        r_sum  <= n_sum;
        r_maxd <= n_maxd;
        r_cell <= n_cell;
    end

    // result item
    assign o_done               = r_done;
    assign o_result.cell_value  = r_cell;
    assign o_result.sweeps_done = r_count;
    assign o_result.converged   = r_conv;

    // checks
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held more than one cycle");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not raise busy");
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= 3'd5) else $error("stencil phase out of range");
    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |=> (r_bank != $past(r_bank)))
        else $error("bank did not flip after sweep");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench of the jacobi laplace grid solver core
// depends on jls_pkg and jacobi_laplace_grid_solver_core; carries its own grid predictor
module tb_top;
    import jls_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    t_cmd_item               i_cmd;
    logic                    o_done;
    t_result_item            o_result;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [VALUE_BITS-1:0]   i_cfg_data;

    jacobi_laplace_grid_solver_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state: registers, both grid banks and last solve status
    logic [6:0]            grid_size_q;
    logic [VALUE_BITS-1:0] edge_q, top_q, start_val_q, tol_q;
    logic [COUNT_BITS-1:0] limit_q;
    logic [VALUE_BITS-1:0] heat_bank [2][MAX_SIDE*MAX_SIDE];
    bit                    cur_bank;
    logic [COUNT_BITS-1:0] last_sweeps;
    logic                  last_conv;
    int                    written_side;

    t_result_item results_pending[$];
    int           errors;
    int           cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[jacobi_laplace_grid_solver_core] ERROR");
            $finish;
        end
    end

    function automatic int side_in_use();
        if (grid_size_q < 3) return 3;
        if (grid_size_q > MAX_SIDE) return MAX_SIDE;
        return int'(grid_size_q);
    endfunction

    task automatic fill_grid();
        int n;
        logic [VALUE_BITS-1:0] v;
        n = side_in_use();
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                if (c == 0 || c == n - 1 || r == n - 1) v = edge_q;
                else if (r == 0) v = top_q;
                else v = start_val_q;
                heat_bank[0][r*MAX_SIDE+c] = v;
                heat_bank[1][r*MAX_SIDE+c] = v;
            end
        if (n > written_side) written_side = n;
    endtask

    task automatic relax_once(output logic [VALUE_BITS-1:0] max_delta);
        int n, k;
        logic [VALUE_BITS+1:0] sum;
        logic [VALUE_BITS-1:0] nv, old, d;
        n = side_in_use();
        max_delta = '0;
        for (int r = 1; r + 1 < n; r++)
            for (int c = 1; c + 1 < n; c++) begin
                k = r * MAX_SIDE + c;
                sum = 26'(heat_bank[cur_bank][k+MAX_SIDE]) + 26'(heat_bank[cur_bank][k-MAX_SIDE])
                    + 26'(heat_bank[cur_bank][k+1]) + 26'(heat_bank[cur_bank][k-1]);
                nv = sum[VALUE_BITS+1:2];
                old = heat_bank[cur_bank][k];
                d = (nv > old) ? nv - old : old - nv;
                if (d > max_delta) max_delta = d;
                heat_bank[!cur_bank][k] = nv;
            end
        cur_bank = !cur_bank;
    endtask

    // expected result of one accepted command
    task automatic heat_predict(input t_cmd_item item);
        t_result_item res;
        logic [VALUE_BITS-1:0] md;
        int cnt, n;
        res = '0;
        case (t_command'(item.command))
            CMD_INIT: fill_grid();
            CMD_SOLVE: begin
                cnt = 0;
                last_conv = 1'b0;
                forever begin
                    relax_once(md);
                    cnt++;
                    if (md < tol_q) begin
                        last_conv = 1'b1;
                        break;
                    end
                    if (cnt >= limit_q) break;
                end
                last_sweeps = cnt[COUNT_BITS-1:0];
            end
            CMD_READ: begin
                n = side_in_use();
                if (item.row < n && item.column < n)
                    res.cell_value = heat_bank[cur_bank][item.row*MAX_SIDE+item.column];
            end
            default: ;
        endcase
        res.sweeps_done = last_sweeps;
        res.converged   = last_conv;
        results_pending.push_back(res);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result_item exp_res;
        if (i_rst_n && o_done) begin
            if (results_pending.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                exp_res = results_pending.pop_front();
                if (o_result.cell_value !== exp_res.cell_value) begin
                    $error("cell_value expected %0d got %0d",
                           exp_res.cell_value, o_result.cell_value);
                    errors++;
                end
                if (o_result.sweeps_done !== exp_res.sweeps_done) begin
                    $error("sweeps_done expected %0d got %0d",
                           exp_res.sweeps_done, o_result.sweeps_done);
                    errors++;
                end
                if (o_result.converged !== exp_res.converged) begin
                    $error("converged expected %0d got %0d",
                           exp_res.converged, o_result.converged);
                    errors++;
                end
            end
        end
    end

    // send one command item; called and returns at a falling edge
    task automatic send_cmd(input t_command op, input int r = 0, input int c = 0);
        t_cmd_item item;
        item.command = op;
        item.row     = r[COORD_BITS-1:0];
        item.column  = c[COORD_BITS-1:0];
        while (busy) @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= item;
        @(negedge i_clk);
        start <= 1'b0;
        heat_predict(item);
        while (busy) @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int k;
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 3);
        if (k > 0) begin
            start <= 1'b0;
            repeat (k) @(negedge i_clk);
        end
    endtask

    // hold off until every expected item has come and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (results_pending.size() != 0 || busy) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[VALUE_BITS-1:0];
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_GRID_SIZE:   grid_size_q = val[6:0];
            REG_EDGE_VALUE:  edge_q = val[VALUE_BITS-1:0];
            REG_TOP_VALUE:   top_q = val[VALUE_BITS-1:0];
            REG_START_VALUE: start_val_q = val[VALUE_BITS-1:0];
            REG_TOLERANCE:   tol_q = val[VALUE_BITS-1:0];
            REG_SWEEP_LIMIT: limit_q = val[COUNT_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic read_corners();
        int n;
        n = side_in_use();
        send_cmd(CMD_READ, 0, 0);
        send_cmd(CMD_READ, 0, n - 1);
        send_cmd(CMD_READ, n - 1, n - 1);
        send_cmd(CMD_READ, 1, 1);
        send_cmd(CMD_READ, 0, n / 2);
    endtask

    // reset register values on the full 64 grid, one capped sweep
    task automatic test_reset_defaults();
        send_cmd(CMD_INIT);
        read_corners();
        write_reg(REG_SWEEP_LIMIT, 1);
        send_cmd(CMD_SOLVE);
        send_cmd(CMD_READ, 62, 62);
        send_cmd(CMD_READ, 63, 63);
    endtask

    // extreme boundary values, converging solves on a small grid
    task automatic test_extremes();
        write_reg(REG_GRID_SIZE, 5);
        write_reg(REG_EDGE_VALUE, 24'hFFFFFF);
        write_reg(REG_TOP_VALUE, 24'hFFFFFF);
        write_reg(REG_START_VALUE, 0);
        write_reg(REG_TOLERANCE, 24'hFFFFFF);
        write_reg(REG_SWEEP_LIMIT, 65535);
        send_cmd(CMD_INIT);
        send_cmd(CMD_SOLVE);
        send_cmd(CMD_READ, 2, 2);
        write_reg(REG_EDGE_VALUE, 0);
        write_reg(REG_TOP_VALUE, 0);
        write_reg(REG_START_VALUE, 24'hFFFFFF);
        write_reg(REG_TOLERANCE, 7);
        write_reg(REG_SWEEP_LIMIT, 300);
        send_cmd(CMD_INIT);
        send_cmd(CMD_SOLVE);
        send_cmd(CMD_READ, 1, 3);
    endtask

    // tolerance zero never converges, sweep limit zero acts as one
    task automatic test_limits();
        write_reg(REG_TOLERANCE, 0);
        write_reg(REG_SWEEP_LIMIT, 4);
        send_cmd(CMD_SOLVE);
        write_reg(REG_SWEEP_LIMIT, 0);
        send_cmd(CMD_SOLVE);
        send_cmd(CMD_READ, 2, 1);
    endtask

    // side clamping, reads outside the side, unused command, shrinking size
    task automatic test_size_and_misc();
        write_reg(REG_GRID_SIZE, 0);
        send_cmd(CMD_INIT);
        send_cmd(CMD_READ, 1, 1);
        send_cmd(CMD_READ, 3, 0);
        send_cmd(CMD_READ, 0, 63);
        send_cmd(CMD_NONE, 63, 63);
        write_reg(REG_GRID_SIZE, 127);
        write_reg(REG_SWEEP_LIMIT, 1);
        send_cmd(CMD_INIT);
        send_cmd(CMD_SOLVE);
        send_cmd(CMD_READ, 63, 0);
        write_reg(REG_GRID_SIZE, 6);
        write_reg(REG_TOLERANCE, 24'h000100);
        write_reg(REG_SWEEP_LIMIT, 20);
        send_cmd(CMD_SOLVE);
        send_cmd(CMD_READ, 5, 5);
    endtask

    // random phases with random settings and weighted commands
    task automatic test_random(input int phases, input int per_phase);
        int sel, sz;
        for (int p = 0; p < phases; p++) begin
            if ($urandom_range(0, 7) == 0) begin
                sz = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
                write_reg(REG_SWEEP_LIMIT, $urandom_range(0, 1));
            end else begin
                sz = $urandom_range(0, 8);
                write_reg(REG_SWEEP_LIMIT, $urandom_range(0, 40));
            end
            write_reg(REG_GRID_SIZE, sz);
            write_reg(REG_EDGE_VALUE, $urandom());
            write_reg(REG_TOP_VALUE, $urandom());
            write_reg(REG_START_VALUE, $urandom());
            write_reg(REG_TOLERANCE, $urandom_range(0, 3) == 0 ? $urandom() :
                                     $urandom_range(0, 32'h10000));
            // a larger side needs a fresh grid before any read or solve
            if (side_in_use() > written_side || $urandom_range(0, 1)) send_cmd(CMD_INIT);
            for (int i = 0; i < per_phase; i++) begin
                sel = $urandom_range(0, 19);
                if (sel < 10) send_cmd(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63));
                else if (sel < 15) send_cmd(CMD_SOLVE);
                else if (sel < 18) send_cmd(CMD_INIT);
                else send_cmd(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63));
                if ($urandom_range(0, 24) == 0) drain();
                else if (p % 3 != 0) idle_gap();
            end
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        grid_size_q = 7'd64;
        edge_q = 24'd6553600;
        top_q = 24'd0;
        start_val_q = 24'd4915200;
        tol_q = 24'd7;
        limit_q = 16'd65535;
        cur_bank = 1'b0;
        last_sweeps = '0;
        last_conv = 1'b0;
        written_side = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_extremes();
        test_limits();
        test_size_and_misc();
        test_random(8, 14);

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && results_pending.size() == 0) begin
            $display("[jacobi_laplace_grid_solver_core] OK");
        end else begin
            $display("[jacobi_laplace_grid_solver_core] ERROR");
        end
        $finish;
    end
endmodule
